// ===== rtl/csmv_pkg.sv =====
// Shared types and constants of the COO sparse matrix-vector core.
package csmv_pkg;

	localparam int IDX_W   = 12;
	localparam int VAL_W   = 32;
	localparam int ACC_W   = 48;
	localparam int FUNC_W  = 2;
	localparam int PROD_W  = 2 * VAL_W;
	localparam int FRAC_W  = 16;
	localparam int ADDR_W  = 3;
	localparam int PDATA_W = 32;

	// queue between front and back, power of two
	localparam int QUEUE_DEPTH = 4;

	// request kinds on s_tuser
	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ENTRY = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

	// register select bit (paddr[2]) of transpose_mode
	localparam logic REG_TRANSPOSE = 1'b0;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] OUT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] OUT_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_W - 1);

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ENTRY = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	// classified request handed from front to back
	typedef struct packed {
		op_t                     op;
		logic                    ok;     // all indices inside the vector depth
		logic [IDX_W-1:0]        dst;    // y index (entry), x/y index (load, read)
		logic [IDX_W-1:0]        src;    // x index of an entry
		logic signed [VAL_W-1:0] value;
	} item_t;

endpackage

// ===== rtl/csmv_queue.sv =====
// Small FIFO of classified requests between front and back.
module csmv_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  csmv_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output csmv_pkg::item_t pop_item,
	output logic            empty
);

	localparam int PW = $clog2(csmv_pkg::QUEUE_DEPTH);

	csmv_pkg::item_t items_q [csmv_pkg::QUEUE_DEPTH];
	logic [PW:0]     wr_q;
	logic [PW:0]     rd_q;

	assign empty    = (wr_q == rd_q);
	assign full     = (wr_q[PW] != rd_q[PW]) && (wr_q[PW-1:0] == rd_q[PW-1:0]);
	assign pop_item = items_q[rd_q[PW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= wr_q + (PW+1)'(1);
			end
			if (pop && !empty) begin
				rd_q <= rd_q + (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			items_q[wr_q[PW-1:0]] <= push_item;
		end
	end

endmodule

// ===== rtl/csmv_front.sv =====
// Front end: configuration register, request intake and classification.
module csmv_front #(
	parameter int VEC_DEPTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [csmv_pkg::ADDR_W-1:0]    paddr,
	input  logic [csmv_pkg::PDATA_W-1:0]   pwdata,
	output logic [csmv_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [55:0]                    s_tdata,
	input  logic [csmv_pkg::FUNC_W-1:0]    s_tuser,
	input  logic                           clearing,
	input  logic                           q_full,
	output logic                           q_push,
	output csmv_pkg::item_t                q_item
);

	logic                             transpose_q;
	logic [csmv_pkg::IDX_W-1:0]       row;
	logic [csmv_pkg::IDX_W-1:0]       col;
	logic                             row_ok;
	logic                             col_ok;
	logic                             keep;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == csmv_pkg::REG_TRANSPOSE) ?
		{{(csmv_pkg::PDATA_W-1){1'b0}}, transpose_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transpose_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
				paddr[2] == csmv_pkg::REG_TRANSPOSE) begin
			transpose_q <= pwdata[0];
		end
	end

	assign s_tready = !q_full && !clearing;

	assign row    = s_tdata[11:0];
	assign col    = s_tdata[23:12];
	assign row_ok = 32'(row) < 32'(VEC_DEPTH);
	assign col_ok = 32'(col) < 32'(VEC_DEPTH);

	always_comb begin
		q_item.value = s_tdata[55:24];
		q_item.dst   = row;
		q_item.src   = row;
		q_item.ok    = row_ok;
		q_item.op    = csmv_pkg::OP_LOAD;
		keep         = 1'b1;
		unique case (s_tuser)
			csmv_pkg::FUNC_LOAD: begin
				q_item.op = csmv_pkg::OP_LOAD;
			end
			csmv_pkg::FUNC_ENTRY: begin
				q_item.op  = csmv_pkg::OP_ENTRY;
				q_item.dst = transpose_q ? col : row;
				q_item.src = transpose_q ? row : col;
				q_item.ok  = row_ok && col_ok;
			end
			csmv_pkg::FUNC_READ: begin
				q_item.op = csmv_pkg::OP_READ;
			end
			default: begin
				// unused code: taken and dropped
				keep = 1'b0;
			end
		endcase
	end

	assign q_push = s_tvalid && s_tready && keep;

endmodule

// ===== rtl/csmv_back.sv =====
// Back end: x and y memories, multiply, round, saturating accumulate, read-out.
module csmv_back #(
	parameter int VEC_DEPTH = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  csmv_pkg::item_t q_item,
	output logic            q_pop,
	output logic            clearing,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [47:0]     m_tdata,
	output logic [0:0]      m_tuser
);

	localparam int AW = $clog2(VEC_DEPTH);
	localparam int YW = csmv_pkg::ACC_W + 1;   // flag on top of accumulator

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FETCH = 4'b0010,
		ST_ROUND = 4'b0100,
		ST_ACC   = 4'b1000
	} state_t;

	logic signed [csmv_pkg::VAL_W-1:0]  x_mem [VEC_DEPTH];
	logic [YW-1:0]                      y_mem [VEC_DEPTH];

	state_t                             state_q, state_d;
	csmv_pkg::item_t                    cur_q;
	logic signed [csmv_pkg::VAL_W-1:0]  x_rd_q;
	logic [YW-1:0]                      y_rd_q;
	logic signed [csmv_pkg::PROD_W-1:0] prod_q;
	logic signed [csmv_pkg::ACC_W-1:0]  rnd_q;
	logic [AW-1:0]                      clr_q;
	logic                               clearing_q;
	logic                               m_valid_q;
	logic [csmv_pkg::IDX_W-1:0]         out_index_q;
	logic [csmv_pkg::VAL_W-1:0]         out_value_q;
	logic                               out_clamped_q;

	logic                               issue;
	logic                               x_we, x_re, y_re, y_we;
	logic [AW-1:0]                      y_waddr;
	logic [YW-1:0]                      y_wdata;
	logic                               out_free;
	logic                               read_done;
	logic [csmv_pkg::PROD_W-1:0]        rnd_full;
	logic signed [csmv_pkg::ACC_W:0]    sum_wide;
	logic                               sum_ovf;
	logic signed [csmv_pkg::ACC_W-1:0]  sum_sat;
	logic [16:0]                        rd_hi;
	logic                               rd_ovf;
	logic [csmv_pkg::VAL_W-1:0]         rd_value;
	logic                               rd_flag;

	assign clearing = clearing_q;
	assign out_free = !m_valid_q || m_tready;
	assign issue    = (state_q == ST_IDLE) && !clearing_q && !q_empty;
	assign q_pop    = issue;

	assign x_we = issue && q_item.op == csmv_pkg::OP_LOAD && q_item.ok;
	assign x_re = issue && q_item.op == csmv_pkg::OP_ENTRY && q_item.ok;
	assign y_re = issue && (q_item.op == csmv_pkg::OP_READ ||
		(q_item.op == csmv_pkg::OP_ENTRY && q_item.ok));

	assign read_done = (state_q == ST_FETCH) && cur_q.op == csmv_pkg::OP_READ && out_free;

	// round Q32.32 to Q32.16, half toward plus infinity
	assign rnd_full = prod_q + csmv_pkg::ROUND_HALF;

	// saturating accumulate
	assign sum_wide = {y_rd_q[csmv_pkg::ACC_W-1], y_rd_q[csmv_pkg::ACC_W-1:0]} +
		{rnd_q[csmv_pkg::ACC_W-1], rnd_q};
	assign sum_ovf  = sum_wide[csmv_pkg::ACC_W] != sum_wide[csmv_pkg::ACC_W-1];
	assign sum_sat  = sum_ovf ?
		(sum_wide[csmv_pkg::ACC_W] ? csmv_pkg::ACC_MIN : csmv_pkg::ACC_MAX) :
		sum_wide[csmv_pkg::ACC_W-1:0];

	// clamp to Q16.16 on read
	assign rd_hi    = y_rd_q[csmv_pkg::ACC_W-1:csmv_pkg::VAL_W-1];
	assign rd_ovf   = !((&rd_hi) || !(|rd_hi));
	assign rd_value = !cur_q.ok ? '0 :
		rd_ovf ? (rd_hi[16] ? csmv_pkg::OUT_MIN : csmv_pkg::OUT_MAX) :
		y_rd_q[csmv_pkg::VAL_W-1:0];
	assign rd_flag  = cur_q.ok && (y_rd_q[YW-1] || rd_ovf);

	// single y write port: clearing pass, read-and-clear, accumulate
	always_comb begin
		y_we    = 1'b0;
		y_waddr = AW'(cur_q.dst);
		y_wdata = '0;
		priority if (clearing_q) begin
			y_we    = 1'b1;
			y_waddr = clr_q;
		end else if (read_done) begin
			y_we = cur_q.ok;
		end else if (state_q == ST_ACC) begin
			y_we    = 1'b1;
			y_wdata = {y_rd_q[YW-1] | sum_ovf, sum_sat};
		end else begin
			y_we = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (issue) begin
					unique case (q_item.op)
						csmv_pkg::OP_ENTRY: state_d = q_item.ok ? ST_FETCH : ST_IDLE;
						csmv_pkg::OP_READ:  state_d = ST_FETCH;
						default:            state_d = ST_IDLE;
					endcase
				end
			end
			ST_FETCH: begin
				if (cur_q.op == csmv_pkg::OP_ENTRY) begin
					state_d = ST_ROUND;
				end else if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_ROUND: state_d = ST_ACC;
			ST_ACC:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			clearing_q <= 1'b1;
			clr_q      <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clearing_q) begin
				if (clr_q == AW'(VEC_DEPTH - 1)) begin
					clearing_q <= 1'b0;
				end else begin
					clr_q <= clr_q + AW'(1);
				end
			end
			if (read_done) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			cur_q <= q_item;
		end
		if (state_q == ST_FETCH) begin
			prod_q <= cur_q.value * x_rd_q;
		end
		if (state_q == ST_ROUND) begin
			rnd_q <= rnd_full[csmv_pkg::PROD_W-1:csmv_pkg::FRAC_W];
		end
		if (read_done) begin
			out_index_q   <= cur_q.dst;
			out_value_q   <= rd_value;
			out_clamped_q <= rd_flag;
		end
	end

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[AW'(q_item.dst)] <= q_item.value;
		end
		if (x_re) begin
			x_rd_q <= x_mem[AW'(q_item.src)];
		end
	end

	always_ff @(posedge clk) begin
		if (y_we) begin
			y_mem[y_waddr] <= y_wdata;
		end
		if (y_re) begin
			y_rd_q <= y_mem[AW'(q_item.dst)];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, out_value_q, out_index_q};
	assign m_tuser  = out_clamped_q;

endmodule

// ===== rtl/coo_sparse_matvec_core.sv =====
// Top level of the COO sparse matrix-vector core.
//
// Requests enter on the s_ stream: tuser selects load of an x element,
// a matrix entry (row, col, value), or read-and-clear of one y element.
// Only read requests give a result on the m_ stream: index, Q16.16 value
// clamped from the 48-bit accumulator, and the clamp flag in tuser.
// transpose_mode sits at APB byte address 0; write it only while idle.
// The front takes a request every cycle while its 4-deep queue has room and no clearing pass runs.
// The back works one request at a time on single-port x and y memories:
// a load writes x when issued, an entry steps through read, multiply, round
// and accumulate-write, and a read fetches y, then waits in its fetch step
// for a free output register; entry pace is set by that y memory sequence.
// A read request passes the queue, is issued with its y word read out, and
// from the fetch step its result is registered to drive m_tvalid.
// After reset a clearing pass zeroes all of y, with s_tready low.
// A stalled result waits in the output register; the back then holds in
// its fetch step on the next read and the queue fills, after which s_tready drops.
module coo_sparse_matvec_core #(
	parameter int VEC_DEPTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// APB configuration
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [csmv_pkg::ADDR_W-1:0]  paddr,
	input  logic [csmv_pkg::PDATA_W-1:0] pwdata,
	output logic [csmv_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	// request stream
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [55:0]                  s_tdata,   // row_index, col_index, data_value
	input  logic [csmv_pkg::FUNC_W-1:0]  s_tuser,   // func
	// result stream
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [47:0]                  m_tdata,   // out_index, out_value, zero pad
	output logic [0:0]                   m_tuser    // clamped
);

	logic            clearing;
	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_empty;
	csmv_pkg::item_t push_item;
	csmv_pkg::item_t pop_item;

	csmv_front #(
		.VEC_DEPTH(VEC_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.clearing (clearing),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	// decouples intake from the multi-cycle back end
	csmv_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	csmv_back #(
		.VEC_DEPTH(VEC_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_item   (pop_item),
		.q_pop    (q_pop),
		.clearing (clearing),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ===== tb/coo_sparse_matvec_core_tb.sv =====
// Self-checking testbench for the COO sparse matrix-vector core: table, then random phases.
module coo_sparse_matvec_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH         = 4096;
	localparam int CYCLE_LIMIT   = 400000;  // clearing pass + worst stalls, many times over
	localparam int SETTLE_CYCLES = 40;      // drains the 4-deep queue of entries, plus pipeline
	localparam int PHASE_ITEMS   = 158;     // counted requests per random phase
	localparam int N_DIR         = 21;
	localparam int HOT_N         = 16;

	// func code the block must swallow without a result
	localparam logic [csmv_pkg::FUNC_W-1:0] FUNC_NONE = 2'd3;

	// transpose_mode register, byte address 0
	localparam logic [csmv_pkg::ADDR_W-1:0] TRANSPOSE_ADDR = {csmv_pkg::REG_TRANSPOSE, 2'b00};

	// Q16.16 corner values
	localparam logic [csmv_pkg::VAL_W-1:0] Q_ONE  = 32'h0001_0000;
	localparam logic [csmv_pkg::VAL_W-1:0] Q_HALF = 32'h0000_8000;
	localparam logic [csmv_pkg::VAL_W-1:0] V_MIN  = 32'h8000_0000;
	localparam logic [csmv_pkg::VAL_W-1:0] V_MAX  = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [csmv_pkg::FUNC_W-1:0] func;
		logic [csmv_pkg::IDX_W-1:0]  row;
		logic [csmv_pkg::IDX_W-1:0]  col;
		logic [csmv_pkg::VAL_W-1:0]  value;
	} request_t;

	typedef struct packed {
		logic [csmv_pkg::IDX_W-1:0] idx;
		logic [csmv_pkg::VAL_W-1:0] value;
		logic                       clamped;
	} readout_t;

	typedef struct packed {
		request_t                   req;
		logic                       typed;        // readout below is known by hand
		logic [csmv_pkg::VAL_W-1:0] exp_value;
		logic                       exp_clamped;
	} dir_row_t;

	// receiver pacing patterns
	typedef enum logic [1:0] {
		RX_OPEN,
		RX_CHOPPY,
		RX_CHOKED
	} rx_mode_t;

	logic                          clk;
	logic                          arst_n   = 1'b0;
	logic                          psel     = 1'b0;
	logic                          penable  = 1'b0;
	logic                          pwrite   = 1'b0;
	logic [csmv_pkg::ADDR_W-1:0]   paddr    = '0;
	logic [csmv_pkg::PDATA_W-1:0]  pwdata   = '0;
	logic [csmv_pkg::PDATA_W-1:0]  prdata;
	logic                          pready;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [55:0]                   s_tdata  = '0;   // row_index, col_index, data_value
	logic [csmv_pkg::FUNC_W-1:0]   s_tuser  = '0;   // func
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [47:0]                   m_tdata;         // out_index, out_value, zero pad
	logic [0:0]                    m_tuser;         // clamped

	// Directed table. The vector x gets x[0] = -1 << 31, x[4095] = max, x[5] = 0.5.
	dir_row_t dir_tab [N_DIR] = '{
		// accumulators read zero after the clearing pass; col and data ignored on read
		'{'{csmv_pkg::FUNC_READ,  12'd0,    12'd0,    32'd0},         1'b1, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_READ,  12'd4095, 12'd4095, V_MAX},         1'b1, 32'd0, 1'b0},
		// unused func code: no result, no state change
		'{'{FUNC_NONE,            12'd5,    12'd7,    32'hDEAD_BEEF}, 1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_LOAD,  12'd0,    12'hABC,  V_MIN},         1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_LOAD,  12'd4095, 12'd0,    V_MAX},         1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_LOAD,  12'd5,    12'd0,    Q_HALF},        1'b0, 32'd0, 1'b0},
		// min*min twice overflows the 48-bit accumulator upward
		'{'{csmv_pkg::FUNC_ENTRY, 12'd4095, 12'd0,    V_MIN},         1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_ENTRY, 12'd4095, 12'd0,    V_MIN},         1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_READ,  12'd4095, 12'd0,    32'd0},         1'b1, V_MAX, 1'b1},
		// read clears value and flag
		'{'{csmv_pkg::FUNC_READ,  12'd4095, 12'd0,    32'd0},         1'b1, 32'd0, 1'b0},
		// min*max three times overflows downward
		'{'{csmv_pkg::FUNC_ENTRY, 12'd2,    12'd4095, V_MIN},         1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_ENTRY, 12'd2,    12'd4095, V_MIN},         1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_ENTRY, 12'd2,    12'd4095, V_MIN},         1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_READ,  12'd2,    12'd0,    32'd0},         1'b1, V_MIN, 1'b1},
		// exact half LSB: +0.5 rounds up to 1, -0.5 rounds up to 0
		'{'{csmv_pkg::FUNC_ENTRY, 12'd3,    12'd5,    32'd1},         1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_ENTRY, 12'd3,    12'd5,    32'hFFFF_FFFF}, 1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_READ,  12'd3,    12'd0,    32'd0},         1'b1, 32'd1, 1'b0},
		// lands exactly on the most negative Q16.16 value, no clamp
		'{'{csmv_pkg::FUNC_ENTRY, 12'd4,    12'd0,    Q_ONE},         1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_READ,  12'd4,    12'hFFF,  32'd0},         1'b1, V_MIN, 1'b0},
		// max*max fits 48 bits but clamps at the 32-bit read
		'{'{csmv_pkg::FUNC_ENTRY, 12'd6,    12'd4095, V_MAX},         1'b0, 32'd0, 1'b0},
		'{'{csmv_pkg::FUNC_READ,  12'd6,    12'd0,    32'd0},         1'b1, V_MAX, 1'b1}
	};

	// predictor state
	bit                                x_seen [DEPTH];
	bit                                transpose_on;
	logic signed [csmv_pkg::VAL_W-1:0] x_vec [DEPTH];
	int                                x_loaded [$];     // x indices safe to use as a source
	longint                            y_acc [DEPTH];
	bit                                y_sat [DEPTH];

	readout_t                   pending_reads [$];      // readouts still owed by the block
	logic [csmv_pkg::IDX_W-1:0] hot_idx [HOT_N];        // small y set so sums build up
	int                         mismatch_count = 0;
	int                         cycle_count    = 0;
	int                         burst_left     = 0;
	int                         rx_left        = 0;
	rx_mode_t                   rx_mode        = RX_OPEN;

	coo_sparse_matvec_core #(
		.VEC_DEPTH (DEPTH)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] MISMATCH %s", $time, msg);
	endfunction

	// Applies one request to the x/y model; returns 1 with the readout for a read.
	function automatic bit matvec_apply(input request_t r, output readout_t res);
		logic [csmv_pkg::IDX_W-1:0] dst;
		logic [csmv_pkg::IDX_W-1:0] src;
		longint                     prod;
		longint                     sum;
		longint                     acc;
		res = '0;
		case (r.func)
			csmv_pkg::FUNC_LOAD: begin
				x_vec[r.row] = r.value;
				if (!x_seen[r.row]) begin
					x_seen[r.row] = 1'b1;
					x_loaded = {x_loaded, int'(r.row)};
				end
				return 1'b0;
			end
			csmv_pkg::FUNC_ENTRY: begin
				dst  = transpose_on ? r.col : r.row;
				src  = transpose_on ? r.row : r.col;
				// exact Q32.32 product, round half up to Q32.16
				prod = longint'($signed(r.value)) * longint'(x_vec[src]);
				sum  = y_acc[dst] + ((prod + 64'sd32768) >>> 16);
				if (sum > longint'(csmv_pkg::ACC_MAX)) begin
					sum        = longint'(csmv_pkg::ACC_MAX);
					y_sat[dst] = 1'b1;
				end else if (sum < longint'(csmv_pkg::ACC_MIN)) begin
					sum        = longint'(csmv_pkg::ACC_MIN);
					y_sat[dst] = 1'b1;
				end
				y_acc[dst] = sum;
				return 1'b0;
			end
			csmv_pkg::FUNC_READ: begin
				acc         = y_acc[r.row];
				res.idx     = r.row;
				res.clamped = y_sat[r.row];
				if (acc > longint'(csmv_pkg::OUT_MAX)) begin
					acc         = longint'(csmv_pkg::OUT_MAX);
					res.clamped = 1'b1;
				end else if (acc < longint'(csmv_pkg::OUT_MIN)) begin
					acc         = longint'(csmv_pkg::OUT_MIN);
					res.clamped = 1'b1;
				end
				res.value    = acc[csmv_pkg::VAL_W-1:0];
				y_acc[r.row] = 0;
				y_sat[r.row] = 1'b0;
				return 1'b1;
			end
			default: begin
				return 1'b0;
			end
		endcase
	endfunction

	// Presents one request, waits for the handshake, books the expected readout,
	// then paces the sender: bursts of random length, some with no gap after them.
	task automatic issue(input request_t r, input logic typed, input readout_t typed_res);
		readout_t res;
		int       gap;
		s_tvalid <= 1'b1;
		s_tuser  <= r.func;
		s_tdata  <= {r.value, r.col, r.row};
		do @(posedge clk); while (!s_tready);
		if (matvec_apply(r, res))
			pending_reads = {pending_reads, (typed ? typed_res : res)};
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Idle the sender until every readout is in, then let queued entries finish.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// APB write of transpose_mode, then read it back.
	task automatic set_transpose(input bit on);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= TRANSPOSE_ADDR;
		pwdata  <= {31'd0, on};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		transpose_on = on;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {31'd0, on})
			log_mismatch($sformatf("transpose_mode readback exp %h act %h", {31'd0, on}, prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver: segments of always-ready, coin-flip, and mostly-stalled.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_left <= $urandom_range(1, 64);
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:   m_tready <= 1'b1;
			RX_CHOPPY: m_tready <= 1'($urandom_range(0, 1));
			default:   m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Result checker: each readout against the oldest one owed.
	always @(posedge clk) begin
		readout_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reads.size() == 0) begin
				log_mismatch($sformatf("readout with none owed: idx %0d value %h clamped %0d",
					m_tdata[11:0], m_tdata[43:12], m_tuser[0]));
			end else begin
				want = pending_reads.pop_front();
				if (m_tdata[11:0] !== want.idx || m_tdata[43:12] !== want.value ||
				    m_tuser[0] !== want.clamped)
					log_mismatch($sformatf(
						"exp idx %0d value %h clamped %0d, act idx %0d value %h clamped %0d",
						want.idx, want.value, want.clamped,
						m_tdata[11:0], m_tdata[43:12], m_tuser[0]));
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("coo_sparse_matvec_core_tb: errors");
			$finish;
		end
	end

	initial begin
		request_t                   req;
		readout_t                   typed_res;
		logic [31:0]                rnd;
		int                         pick;
		int                         issued;
		int                         src;
		logic [csmv_pkg::IDX_W-1:0] dst;

		hot_idx[0] = '0;
		hot_idx[1] = '1;
		for (int i = 2; i < HOT_N; i++)
			hot_idx[i] = csmv_pkg::IDX_W'($urandom);

		// single reset at start; the block then clears y with s_tready low
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed table in plain mode (transpose_mode resets to 0)
		for (int i = 0; i < N_DIR; i++) begin
			typed_res.idx     = dir_tab[i].req.row;
			typed_res.value   = dir_tab[i].exp_value;
			typed_res.clamped = dir_tab[i].exp_clamped;
			issue(dir_tab[i].req, dir_tab[i].typed, typed_res);
		end
		settle();

		// random phases, alternating transpose on/off; each ends fully drained
		for (int ph = 0; ph < 4; ph++) begin
			set_transpose(ph % 2 == 0);
			issued = 0;
			while (issued < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				rnd  = $urandom;
				// full-range data sometimes, else small values that rarely saturate
				req.value = ($urandom_range(0, 9) < 4) ? rnd : {{12{rnd[19]}}, rnd[19:0]};
				req.col   = csmv_pkg::IDX_W'($urandom);
				req.row   = csmv_pkg::IDX_W'($urandom);
				if (pick < 20) begin
					req.func = csmv_pkg::FUNC_LOAD;
					if ($urandom_range(0, 1) == 0)
						req.row = hot_idx[$urandom_range(0, HOT_N - 1)];
				end else if (pick < 68) begin
					// source only from loaded x entries
					req.func = csmv_pkg::FUNC_ENTRY;
					src = x_loaded[$urandom_range(0, x_loaded.size() - 1)];
					dst = ($urandom_range(0, 4) != 0) ?
						hot_idx[$urandom_range(0, HOT_N - 1)] : csmv_pkg::IDX_W'($urandom);
					if (transpose_on) begin
						req.row = csmv_pkg::IDX_W'(src);
						req.col = dst;
					end else begin
						req.row = dst;
						req.col = csmv_pkg::IDX_W'(src);
					end
				end else if (pick < 95) begin
					req.func = csmv_pkg::FUNC_READ;
					if ($urandom_range(0, 3) != 0)
						req.row = hot_idx[$urandom_range(0, HOT_N - 1)];
				end else begin
					req.func = FUNC_NONE;
				end
				issue(req, 1'b0, '0);
				if (req.func != FUNC_NONE)
					issued++;
			end
			settle();
		end

		if (mismatch_count == 0)
			$display("coo_sparse_matvec_core_tb: clean");
		else
			$display("coo_sparse_matvec_core_tb: errors");
		$finish;
	end

endmodule

// ===== coo_sparse_matvec_core.f =====
rtl/csmv_pkg.sv
rtl/csmv_queue.sv
rtl/csmv_front.sv
rtl/csmv_back.sv
rtl/coo_sparse_matvec_core.sv
tb/coo_sparse_matvec_core_tb.sv
